@@ rtl/image_median_filter_core_assert.svh @@
// Assertion macros for the median filter RTL.
`ifndef IMAGE_MEDIAN_FILTER_CORE_ASSERT_SVH
`define IMAGE_MEDIAN_FILTER_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define IMF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define IMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/imf_pkg.sv @@
// Shared types and constants of the median filter.
`default_nettype none

package imf_pkg;

	localparam int DIM_W    = 11;
	localparam int KW       = 3;
	localparam int CHN_W    = 3;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 11;
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 2 * DIM_W + CHN_W;
	localparam int HALF_W   = 3;
	localparam int SLOT_W   = 4;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;
	localparam int OUTS_W   = 3;
	localparam int SETTLE_W = 2;

	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;
	localparam logic                OP_SAMPLE     = 1'b0;

	typedef enum logic [CIDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_WINDOW_SIZE   = 3'd2,
		REG_CHANNEL_COUNT = 3'd3,
		REG_SAMPLE_SIGNED = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [HALF_W-1:0] half;
		logic              sgn;
	} geom_t;

	typedef struct packed {
		logic [CHN_W-1:0]  ch;
		logic [DIM_W-1:0]  x;
		logic [DIM_W-1:0]  y;
		logic [SLOT_W-1:0] slot;
		logic              eof;
	} job_t;

	typedef struct packed {
		logic                en;
		logic [SLOT_W-1:0]   slot;
		logic [DIM_W-1:0]    x;
		logic [CHN_W-1:0]    ch;
		logic [SAMPLE_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic              wr_en;
		logic              push;
		logic [OUTS_W-1:0] outstanding;
	} front_stat_t;

	typedef struct packed {
		logic pop;
		logic gather_done;
	} back_stat_t;

endpackage

`default_nettype wire

@@ rtl/imf_queue.sv @@
// Short job queue between the front and the back of the median filter.
`default_nettype none

module imf_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  imf_pkg::job_t   push_job,
	output logic            full,
	input  wire             pop,
	output logic            empty,
	output imf_pkg::job_t   head_job
);

	imf_pkg::job_t                   slot_q [imf_pkg::QDEPTH];
	logic [imf_pkg::QPTR_W-1:0]      wptr_q;
	logic [imf_pkg::QPTR_W-1:0]      rptr_q;
	logic [imf_pkg::QCNT_W-1:0]      count_q;

	assign full     = (count_q == imf_pkg::QCNT_W'(imf_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rptr_q];

	// Store the pushed job.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/imf_front.sv @@
// Front end: configuration, frame positions, store writes and job issue.
`default_nettype none

module imf_front #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_WINDOW   = 7,
	parameter int MAX_CHANNELS = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [imf_pkg::CIDX_W-1:0]       cfg_index,
	input  wire  [imf_pkg::CDATA_W-1:0]      cfg_data,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire                              s_tuser,
	input  wire  [imf_pkg::SAMPLE_W-1:0]     s_tdata,
	input  wire                              q_full,
	input  imf_pkg::back_stat_t              bstat,
	output imf_pkg::job_t                    q_job,
	output imf_pkg::store_wr_t               store_wr,
	output imf_pkg::geom_t                   geom,
	output imf_pkg::front_stat_t             fstat
);

	localparam int HALF_MAX  = (MAX_WINDOW - 1) / 2;
	localparam int ROW_SLOTS = 2 * HALF_MAX + 1;

	localparam int DW = imf_pkg::DIM_W;
	localparam int PW = imf_pkg::POS_W;

	logic [DW-1:0]                   fw_q, fh_q;
	logic [imf_pkg::KW-1:0]          ws_q;
	logic [imf_pkg::CHN_W-1:0]       cc_q;
	logic                            sgn_q;
	logic [imf_pkg::SETTLE_W-1:0]    settle_q;

	logic [DW-1:0]                   w_eff, h_eff;
	logic [imf_pkg::CHN_W-1:0]       c_eff;
	logic [imf_pkg::KW-1:0]          ws_odd;
	logic [imf_pkg::HALF_W-1:0]      half_raw, half_eff;

	logic [2*DW-1:0]                 wh_s1;
	logic [imf_pkg::HALF_W+DW-1:0]   hw_s1;
	logic [imf_pkg::CHN_W-1:0]       c_s1;
	logic [imf_pkg::HALF_W-1:0]      half_s1;
	logic [PW-1:0]                   total_s2, delay_s2;

	logic [PW-1:0]                   in_pos_q, out_pos_q;
	logic [imf_pkg::CHN_W-1:0]       in_ch_q, out_ch_q;
	logic [DW-1:0]                   in_x_q, out_x_q, out_y_q;
	logic [imf_pkg::SLOT_W-1:0]      in_slot_q, out_slot_q;
	logic [imf_pkg::OUTS_W-1:0]      outs_q;

	logic                            wr, emit, eof, acc, cfg_wr;
	logic [PW-1:0]                   in_next;

	// Clamp the registers to the usable geometry.
	always_comb begin
		w_eff = fw_q;
		if (fw_q == '0) begin
			w_eff = DW'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w_eff = DW'(MAX_WIDTH);
		end
		h_eff = (fh_q == '0) ? DW'(1) : fh_q;
		c_eff = cc_q;
		if (cc_q == '0) begin
			c_eff = imf_pkg::CHN_W'(1);
		end else if (int'(cc_q) > MAX_CHANNELS) begin
			c_eff = imf_pkg::CHN_W'(MAX_CHANNELS);
		end
		ws_odd = ws_q;
		if (ws_q == '0) begin
			ws_odd = imf_pkg::KW'(1);
		end else if (!ws_q[0]) begin
			ws_odd = ws_q - 1'b1;
		end
		half_raw = imf_pkg::HALF_W'((ws_odd - 1'b1) >> 1);
		half_eff = (int'(half_raw) > HALF_MAX) ? imf_pkg::HALF_W'(HALF_MAX) : half_raw;
	end

	// Derive frame size and output delay in two steps.
	always_ff @(posedge clk) begin
		wh_s1    <= w_eff * h_eff;
		hw_s1    <= half_eff * w_eff;
		c_s1     <= c_eff;
		half_s1  <= half_eff;
		total_s2 <= PW'(wh_s1 * c_s1);
		delay_s2 <= PW'((hw_s1 + (imf_pkg::HALF_W+DW)'(half_s1)) * c_s1);
	end

	assign geom.w    = w_eff;
	assign geom.h    = h_eff;
	assign geom.half = half_eff;
	assign geom.sgn  = sgn_q;

	// Decide what this beat does.
	always_comb begin
		wr      = (s_tuser == imf_pkg::OP_SAMPLE) && (in_pos_q < total_s2);
		in_next = in_pos_q + PW'(wr);
		emit    = (out_pos_q < total_s2) &&
			((in_next >= total_s2) ||
			({1'b0, in_next} > ({1'b0, out_pos_q} + {1'b0, delay_s2})));
		eof     = ((out_pos_q + 1'b1) == total_s2);
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign s_tready  = (settle_q == '0) && !q_full && (!wr || outs_q == '0);
	assign acc       = s_tvalid && s_tready;

	assign store_wr.en   = acc && wr;
	assign store_wr.slot = in_slot_q;
	assign store_wr.x    = in_x_q;
	assign store_wr.ch   = in_ch_q;
	assign store_wr.data = s_tdata;

	assign q_job.ch   = out_ch_q;
	assign q_job.x    = out_x_q;
	assign q_job.y    = out_y_q;
	assign q_job.slot = out_slot_q;
	assign q_job.eof  = eof;

	assign fstat.wr_en       = acc && wr;
	assign fstat.push        = acc && emit;
	assign fstat.outstanding = outs_q;

	// Hold configuration and frame positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= DW'(1024);
			fh_q       <= DW'(1024);
			ws_q       <= imf_pkg::KW'(3);
			cc_q       <= imf_pkg::CHN_W'(1);
			sgn_q      <= 1'b0;
			settle_q   <= imf_pkg::SETTLE_CYCLES;
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			in_ch_q    <= '0;
			in_x_q     <= '0;
			in_slot_q  <= '0;
			out_ch_q   <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_slot_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				imf_pkg::REG_FRAME_WIDTH:   fw_q  <= cfg_data;
				imf_pkg::REG_FRAME_HEIGHT:  fh_q  <= cfg_data;
				imf_pkg::REG_WINDOW_SIZE:   ws_q  <= cfg_data[imf_pkg::KW-1:0];
				imf_pkg::REG_CHANNEL_COUNT: cc_q  <= cfg_data[imf_pkg::CHN_W-1:0];
				imf_pkg::REG_SAMPLE_SIGNED: sgn_q <= cfg_data[0];
				default: ;
			endcase
			if (cfg_index <= imf_pkg::REG_SAMPLE_SIGNED) begin
				settle_q   <= imf_pkg::SETTLE_CYCLES;
				in_pos_q   <= '0;
				out_pos_q  <= '0;
				in_ch_q    <= '0;
				in_x_q     <= '0;
				in_slot_q  <= '0;
				out_ch_q   <= '0;
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_slot_q <= '0;
			end
		end else begin
			if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			// Advance the write position.
			if (acc && wr) begin
				in_pos_q <= in_next;
				if (in_ch_q + 1'b1 == c_eff) begin
					in_ch_q <= '0;
					if (in_x_q + 1'b1 == w_eff) begin
						in_x_q <= '0;
						if (in_slot_q == imf_pkg::SLOT_W'(ROW_SLOTS - 1)) begin
							in_slot_q <= '0;
						end else begin
							in_slot_q <= in_slot_q + 1'b1;
						end
					end else begin
						in_x_q <= in_x_q + 1'b1;
					end
				end else begin
					in_ch_q <= in_ch_q + 1'b1;
				end
			end
			// Advance the output position; restart after the frame's last output.
			if (acc && emit) begin
				if (eof) begin
					in_pos_q   <= '0;
					out_pos_q  <= '0;
					in_ch_q    <= '0;
					in_x_q     <= '0;
					in_slot_q  <= '0;
					out_ch_q   <= '0;
					out_x_q    <= '0;
					out_y_q    <= '0;
					out_slot_q <= '0;
				end else begin
					out_pos_q <= out_pos_q + 1'b1;
					if (out_ch_q + 1'b1 == c_eff) begin
						out_ch_q <= '0;
						if (out_x_q + 1'b1 == w_eff) begin
							out_x_q <= '0;
							out_y_q <= out_y_q + 1'b1;
							if (out_slot_q == imf_pkg::SLOT_W'(ROW_SLOTS - 1)) begin
								out_slot_q <= '0;
							end else begin
								out_slot_q <= out_slot_q + 1'b1;
							end
						end else begin
							out_x_q <= out_x_q + 1'b1;
						end
					end else begin
						out_ch_q <= out_ch_q + 1'b1;
					end
				end
			end
		end
	end

	// Count jobs whose window is not yet read out of the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outs_q <= '0;
		end else begin
			case ({acc && emit, bstat.gather_done})
				2'b10:   outs_q <= outs_q + 1'b1;
				2'b01:   outs_q <= outs_q - 1'b1;
				default: outs_q <= outs_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/imf_back.sv @@
// Back end: line store, window gather, median select and result register.
`default_nettype none

module imf_back #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_WINDOW   = 7,
	parameter int MAX_CHANNELS = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  imf_pkg::store_wr_t               store_wr,
	input  imf_pkg::geom_t                   geom,
	input  wire                              q_empty,
	input  imf_pkg::job_t                    q_head,
	output imf_pkg::back_stat_t              bstat,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [imf_pkg::SAMPLE_W-1:0]     m_tdata,
	output logic                             m_tlast
);

	localparam int HALF_MAX  = (MAX_WINDOW - 1) / 2;
	localparam int ROW_SLOTS = 2 * HALF_MAX + 1;
	localparam int KCAP      = (ROW_SLOTS < 7) ? ROW_SLOTS : 7;
	localparam int WIN_N     = KCAP * KCAP;
	localparam int CNT_W     = $clog2(WIN_N + 1);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SLOTB     = $clog2(ROW_SLOTS);
	localparam int ADDR_W    = SLOTB + COL_W + CH_W;
	localparam int DEPTH     = ROW_SLOTS << (COL_W + CH_W);
	localparam int SW        = imf_pkg::SAMPLE_W;
	localparam int DW        = imf_pkg::DIM_W;
	localparam int CW        = 15;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_READ = 4'b0010,
		B_SORT = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t                       state_q;
	imf_pkg::job_t                 job_q;
	logic [imf_pkg::KW-1:0]        dx_q, dy_q;
	logic                          iss_done_q;
	logic                          rv_s1, last_s1;
	logic [SW-1:0]                 rd_data_s1;
	logic [SW-1:0]                 store_q [DEPTH];
	logic [SW-1:0]                 win_q [WIN_N];
	logic [WIN_N-1:0]              mask_q;
	logic [WIN_N-1:0]              lt_s1, le_s1;
	logic [SW-1:0]                 cval_s1, med_q;
	logic                          cok_s1;
	logic                          mv_q, ml_q;
	logic [SW-1:0]                 md_q;

	logic [imf_pkg::KW-1:0]        kk;
	logic [7:0]                    n_win, m_idx;
	logic                          issue, last_iss, found, gather_end;
	logic signed [CW-1:0]          ry, rx, ry_c, rx_c, dsl;
	logic signed [5:0]             ss;
	logic [ADDR_W-1:0]             raddr, waddr;
	logic [SW-1:0]                 sflip;
	logic [CNT_W-1:0]              n_lt, n_le;
	logic [COL_W-1:0]              rcol, wcol;

	// Last tap offset, tap count and middle rank.
	always_comb begin
		kk    = imf_pkg::KW'({geom.half, 1'b0});
		n_win = 8'((kk + 1'b1) * (kk + 1'b1));
		m_idx = (n_win - 1'b1) >> 1;
		sflip = {geom.sgn, {(SW-1){1'b0}}};
	end

	// Clamp the tap to the frame and map its row to a store slot.
	always_comb begin
		ry   = $signed(CW'(job_q.y)) + $signed(CW'(dy_q)) - $signed(CW'(geom.half));
		rx   = $signed(CW'(job_q.x)) + $signed(CW'(dx_q)) - $signed(CW'(geom.half));
		ry_c = ry;
		if (ry < 0) begin
			ry_c = '0;
		end else if (ry > $signed(CW'(geom.h) - CW'(1))) begin
			ry_c = $signed(CW'(geom.h) - CW'(1));
		end
		rx_c = rx;
		if (rx < 0) begin
			rx_c = '0;
		end else if (rx > $signed(CW'(geom.w) - CW'(1))) begin
			rx_c = $signed(CW'(geom.w) - CW'(1));
		end
		dsl = ry_c - $signed(CW'(job_q.y));
		ss  = $signed(6'(job_q.slot)) + $signed(dsl[5:0]);
		if (ss < 0) begin
			ss = ss + 6'(ROW_SLOTS);
		end else if (ss >= $signed(6'(ROW_SLOTS))) begin
			ss = ss - 6'(ROW_SLOTS);
		end
		rcol  = rx_c[COL_W-1:0];
		raddr = {ss[SLOTB-1:0], rcol, job_q.ch[CH_W-1:0]};
		wcol  = COL_W'({4'b0, store_wr.x});
		waddr = {store_wr.slot[SLOTB-1:0], wcol, store_wr.ch[CH_W-1:0]};
	end

	assign issue      = (state_q == B_READ) && !iss_done_q;
	assign last_iss   = (dx_q == kk) && (dy_q == kk);
	assign gather_end = rv_s1 && last_s1;

	assign bstat.pop         = (state_q == B_IDLE) && !q_empty;
	assign bstat.gather_done = gather_end;

	// Line store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			store_q[waddr] <= store_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= store_q[raddr];
		end
	end

	// Shift taps in during gather, rotate candidates during select.
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			for (int j = 0; j < WIN_N - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[WIN_N-1] <= rd_data_s1;
		end else if (state_q == B_SORT) begin
			for (int j = 0; j < WIN_N; j++) begin
				win_q[j] <= win_q[(j + 1) % WIN_N];
			end
		end
		if (gather_end) begin
			for (int j = 0; j < WIN_N; j++) begin
				mask_q[j] <= (j >= WIN_N - int'(n_win));
			end
		end else if (state_q == B_SORT) begin
			mask_q <= {mask_q[0], mask_q[WIN_N-1:1]};
		end
	end

	// Compare every tap against the current candidate.
	always_ff @(posedge clk) begin
		for (int j = 0; j < WIN_N; j++) begin
			lt_s1[j] <= mask_q[j] && ((win_q[j] ^ sflip) <  (win_q[0] ^ sflip));
			le_s1[j] <= mask_q[j] && ((win_q[j] ^ sflip) <= (win_q[0] ^ sflip));
		end
		cval_s1 <= win_q[0];
	end

	// Rank the candidate.
	always_comb begin
		n_lt  = CNT_W'($countones(lt_s1));
		n_le  = CNT_W'($countones(le_s1));
		found = cok_s1 && (state_q == B_SORT) &&
			(8'(n_lt) <= m_idx) && (8'(n_le) > m_idx);
	end

	always_ff @(posedge clk) begin
		if (bstat.pop) begin
			job_q <= q_head;
		end
		if (found) begin
			med_q <= cval_s1;
		end
		if ((state_q == B_OUT) && (!mv_q || m_tready)) begin
			md_q <= med_q;
			ml_q <= job_q.eof;
		end
	end

	// Sequence one job: gather, select, hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			dx_q       <= '0;
			dy_q       <= '0;
			iss_done_q <= 1'b0;
			rv_s1      <= 1'b0;
			last_s1    <= 1'b0;
			cok_s1     <= 1'b0;
			mv_q       <= 1'b0;
		end else begin
			rv_s1   <= issue;
			last_s1 <= issue && last_iss;
			cok_s1  <= (state_q == B_SORT) && mask_q[0];
			if (mv_q && m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						dx_q       <= '0;
						dy_q       <= '0;
						iss_done_q <= 1'b0;
						state_q    <= B_READ;
					end
				end
				B_READ: begin
					if (issue) begin
						if (last_iss) begin
							iss_done_q <= 1'b1;
						end else if (dx_q == kk) begin
							dx_q <= '0;
							dy_q <= dy_q + 1'b1;
						end else begin
							dx_q <= dx_q + 1'b1;
						end
					end
					if (gather_end) begin
						state_q <= B_SORT;
					end
				end
				B_SORT: begin
					if (found) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!mv_q || m_tready) begin
						mv_q    <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tlast  = ml_q;

endmodule

`default_nettype wire

@@ rtl/image_median_filter_core.sv @@
// Top level of the streaming two-dimensional median filter.
//
// Input stream: one beat per sample, raster order with channels interleaved;
// s_tuser low carries a sample in s_tdata, s_tuser high is a flush tick that
// drives out pending outputs once the frame is in. Output stream: one beat per
// pixel channel with the window median, m_tlast on the frame's last output.
// Configuration: cfg_index selects frame_width, frame_height, window_size,
// channel_count or sample_signed; cfg_ready is always high and a write to
// one of them restarts the frame. Items are held off after a write until
// the settle counter has run down. The back end takes one job at a time:
// it reads the k*k window through the single read port of the line store,
// then ranks it, one candidate a cycle, and hands the median over.
// Flush beats are taken one a cycle while the four-entry job queue has room;
// a sample beat waits until every pending window has been read out.
// An output's job is issued the first step past (half*w+half)*c samples;
// the result then passes the gather, the select and the output register.
// Reset: positions clear, registers return to 1024x1024, k=3, one channel,
// unsigned. When the receiver stalls, the result is held in the output register
// and the queue absorbs up to four further jobs before flush beats are held off.
`default_nettype none

module image_median_filter_core #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_WINDOW   = 7,
	parameter int MAX_CHANNELS = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [imf_pkg::CIDX_W-1:0]       cfg_index,
	input  wire  [imf_pkg::CDATA_W-1:0]      cfg_data,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [imf_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
	input  wire                              s_tuser,   // [0] operation
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [imf_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] median
	output logic                             m_tlast
);

	imf_pkg::job_t         q_job, q_head;
	imf_pkg::store_wr_t    store_wr;
	imf_pkg::geom_t        geom;
	imf_pkg::front_stat_t  fstat;
	imf_pkg::back_stat_t   bstat;
	logic                  q_full, q_empty;

	imf_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_WINDOW   (MAX_WINDOW),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.bstat     (bstat),
		.q_job     (q_job),
		.store_wr  (store_wr),
		.geom      (geom),
		.fstat     (fstat)
	);

	imf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fstat.push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (bstat.pop),
		.empty    (q_empty),
		.head_job (q_head)
	);

	imf_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_WINDOW   (MAX_WINDOW),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.store_wr (store_wr),
		.geom     (geom),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.bstat    (bstat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`include "image_median_filter_core_assert.svh"

	`IMF_ASSERT_IMP(a_write_after_gather, fstat.wr_en, fstat.outstanding == '0, "store write while a window is pending")
	`IMF_ASSERT_IMP(a_push_has_room, fstat.push, !q_full, "job pushed into a full queue")
	`IMF_ASSERT_IMP(a_gather_owned, bstat.gather_done, fstat.outstanding != '0, "gather done with no job outstanding")
	`IMF_ASSERT_NXT(a_gather_retires, bstat.gather_done && !fstat.push, fstat.outstanding == $past(fstat.outstanding) - 3'd1, "outstanding count not retired")

endmodule

`default_nettype wire
